>>> src/stwq_pkg.sv
// Package for the sorted timer wait queue: word types, codes and defaults.
// Depends on nothing; the slot store and the top module import it.
`timescale 1ns / 1ps

package stwq_pkg;

  localparam int unsigned NumTimersDef = 16;
  localparam int unsigned TickBitsDef  = 32;

  localparam int unsigned IdW      = 4;
  localparam int unsigned WordTickW = 32;

  typedef enum logic [0:0] {
    FuncInsert = 1'b0,
    FuncRemove = 1'b1
  } stwq_func_e;

  typedef enum logic [1:0] {
    StatOk        = 2'd0,
    StatNoAction  = 2'd1,
    StatRunning   = 2'd2,
    StatNotActive = 2'd3
  } stwq_status_e;

  typedef struct packed {
    stwq_func_e            func;
    logic [IdW-1:0]        timer_id;
    logic [WordTickW-1:0]  now_tick;
    logic [WordTickW-1:0]  period;
    logic                  has_action;
  } stwq_in_t;

  typedef struct packed {
    stwq_status_e          status;
    logic [IdW-1:0]        slot_id;
    logic [WordTickW-1:0]  wake_time;
    logic                  went_overflow;
    logic                  cur_head_valid;
    logic [IdW-1:0]        cur_head_id;
    logic [WordTickW-1:0]  cur_head_tick;
    logic                  ovf_head_valid;
    logic [IdW-1:0]        ovf_head_id;
    logic [WordTickW-1:0]  ovf_head_tick;
  } stwq_out_t;

  // Write strobes of the slot store, one per memory.
  typedef struct packed {
    logic tick;
    logic next;
    logic prev;
  } stwq_we_t;

endpackage

>>> src/stwq_cmp.sv
// Shared tick comparator: a < b, or a <= b when or_equal_i is set.
// Depends on nothing; used by the sequencer for the wrap test and each list step.
`timescale 1ns / 1ps

module stwq_cmp #(
  parameter int unsigned TICK_BITS = 32
) (
  input  logic [TICK_BITS-1:0] a_i,
  input  logic [TICK_BITS-1:0] b_i,
  input  logic                 or_equal_i,
  output logic                 hit_o
);

  always_comb begin
    if (or_equal_i) begin
      hit_o = (a_i <= b_i);
    end else begin
      hit_o = (a_i < b_i);
    end
  end

endmodule

>>> src/stwq_store.sv
// Slot store: wake tick, next link and prev link memories of the timer pool.
// Depends on stwq_pkg; one write port per memory, one shared read address with registered read data.
`timescale 1ns / 1ps

module stwq_store #(
  parameter int unsigned NUM_TIMERS = 16,
  parameter int unsigned TICK_BITS  = 32,
  localparam int unsigned SlotW = $clog2(NUM_TIMERS),
  localparam int unsigned LinkW = SlotW + 1
) (
  input  logic                 clk_i,
  input  stwq_pkg::stwq_we_t   we_i,
  input  logic [SlotW-1:0]     tick_waddr_i,
  input  logic [TICK_BITS-1:0] tick_wdata_i,
  input  logic [SlotW-1:0]     next_waddr_i,
  input  logic [LinkW-1:0]     next_wdata_i,
  input  logic [SlotW-1:0]     prev_waddr_i,
  input  logic [LinkW-1:0]     prev_wdata_i,
  input  logic [SlotW-1:0]     raddr_i,
  output logic [TICK_BITS-1:0] tick_rdata_o,
  output logic [LinkW-1:0]     next_rdata_o,
  output logic [LinkW-1:0]     prev_rdata_o
);

  import stwq_pkg::*;

  logic [TICK_BITS-1:0] tick_mem [NUM_TIMERS];
  logic [LinkW-1:0]     next_mem [NUM_TIMERS];
  logic [LinkW-1:0]     prev_mem [NUM_TIMERS];

  always_ff @(posedge clk_i) begin
    if (we_i.tick) begin
      tick_mem[tick_waddr_i] <= tick_wdata_i;
    end
    if (we_i.next) begin
      next_mem[next_waddr_i] <= next_wdata_i;
    end
    if (we_i.prev) begin
      prev_mem[prev_waddr_i] <= prev_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_rdata_o <= tick_mem[raddr_i];
    next_rdata_o <= next_mem[raddr_i];
    prev_rdata_o <= prev_mem[raddr_i];
  end

endmodule

>>> src/sorted_timer_wait_queue_top.sv
// Sorted timer wait queue: sequencer, list heads and running flags.
// Depends on stwq_pkg, stwq_store and stwq_cmp.
//
//   channel | direction | handshake                 | word
//   in      | to block  | in_valid_i / in_ready_o   | stwq_in_t  (operation)
//   out     | from block| out_valid_o / out_ready_i | stwq_out_t (status and heads)
//
// Insert: walks k list entries (0 .. NUM_TIMERS - 1) one per cycle through the single
// read port of the slot store, then StLink1 and StLink2. Remove: StRmLink, StRmTick.
// in_ready_o is high only while the sequencer is idle.
// Reset empties both lists and clears every running flag; no clearing pass.
// A held result stalls the sequencer in its final state until taken.
`timescale 1ns / 1ps

module sorted_timer_wait_queue_top #(
  parameter int unsigned NUM_TIMERS = stwq_pkg::NumTimersDef,
  parameter int unsigned TICK_BITS  = stwq_pkg::TickBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stwq_pkg::stwq_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stwq_pkg::stwq_out_t out_data_o
);

  import stwq_pkg::*;

  localparam int unsigned SlotW = $clog2(NUM_TIMERS);
  localparam int unsigned LinkW = SlotW + 1;
  localparam int unsigned IdCount = 2 ** IdW;

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StWalk   = 7'b0000010,
    StLink1  = 7'b0000100,
    StLink2  = 7'b0001000,
    StRmLink = 7'b0010000,
    StRmTick = 7'b0100000,
    StDone   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [SlotW-1:0]     slot_q, slot_d;
  logic [IdW-1:0]       id_q, id_d;
  stwq_func_e           func_q, func_d;
  stwq_status_e         status_q, status_d;
  logic [TICK_BITS-1:0] wake_q, wake_d;
  logic                 ovf_q, ovf_d;
  logic [LinkW-1:0]     at_q, at_d;
  logic [LinkW-1:0]     before_q, before_d;
  logic [LinkW-1:0]     cur_head_q, cur_head_d;
  logic [TICK_BITS-1:0] cur_tick_q, cur_tick_d;
  logic [LinkW-1:0]     ovf_head_q, ovf_head_d;
  logic [TICK_BITS-1:0] ovf_tick_q, ovf_tick_d;
  logic                 rm_cur_q, rm_cur_d;
  logic                 rm_ovf_q, rm_ovf_d;
  logic [NUM_TIMERS-1:0] running_q, running_d;
  logic                 out_valid_q, out_valid_d;
  stwq_out_t            out_q, out_d;

  // Slot number of each possible id, taken modulo the pool size.
  logic [SlotW-1:0] id_to_slot [IdCount];
  for (genvar g = 0; g < IdCount; g++) begin : g_id_map
    assign id_to_slot[g] = SlotW'(g % NUM_TIMERS);
  end

  logic [SlotW-1:0]     slot_c;
  logic [TICK_BITS-1:0] now_c, period_c, wake_c;
  logic [LinkW-1:0]     self_link;
  logic                 accept;
  logic                 load_out;

  assign slot_c    = id_to_slot[in_data_i.timer_id];
  assign now_c     = TICK_BITS'(in_data_i.now_tick);
  assign period_c  = TICK_BITS'(in_data_i.period);
  assign wake_c    = now_c + period_c;
  assign self_link = {1'b1, slot_q};
  assign accept    = in_valid_i && in_ready_o;

  // Shared comparator
  logic [TICK_BITS-1:0] cmp_a, cmp_b;
  logic                 cmp_eq, cmp_hit;

  // Slot store ports
  stwq_we_t             we;
  logic [SlotW-1:0]     tick_waddr, next_waddr, prev_waddr, raddr;
  logic [TICK_BITS-1:0] tick_wdata;
  logic [LinkW-1:0]     next_wdata, prev_wdata;
  logic [TICK_BITS-1:0] rd_tick;
  logic [LinkW-1:0]     rd_next, rd_prev;

  stwq_cmp #(
    .TICK_BITS (TICK_BITS)
  ) u_cmp (
    .a_i        (cmp_a),
    .b_i        (cmp_b),
    .or_equal_i (cmp_eq),
    .hit_o      (cmp_hit)
  );

  stwq_store #(
    .NUM_TIMERS (NUM_TIMERS),
    .TICK_BITS  (TICK_BITS)
  ) u_store (
    .clk_i        (clk_i),
    .we_i         (we),
    .tick_waddr_i (tick_waddr),
    .tick_wdata_i (tick_wdata),
    .next_waddr_i (next_waddr),
    .next_wdata_i (next_wdata),
    .prev_waddr_i (prev_waddr),
    .prev_wdata_i (prev_wdata),
    .raddr_i      (raddr),
    .tick_rdata_o (rd_tick),
    .next_rdata_o (rd_next),
    .prev_rdata_o (rd_prev)
  );

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Comparator operands: wrap test while idle, list order while walking.
  always_comb begin
    if (state_q == StWalk) begin
      cmp_a  = rd_tick;
      cmp_b  = wake_q;
      cmp_eq = ovf_q;
    end else begin
      cmp_a  = wake_c;
      cmp_b  = now_c;
      cmp_eq = 1'b0;
    end
  end

  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    id_d       = id_q;
    func_d     = func_q;
    status_d   = status_q;
    wake_d     = wake_q;
    ovf_d      = ovf_q;
    at_d       = at_q;
    before_d   = before_q;
    cur_head_d = cur_head_q;
    cur_tick_d = cur_tick_q;
    ovf_head_d = ovf_head_q;
    ovf_tick_d = ovf_tick_q;
    rm_cur_d   = rm_cur_q;
    rm_ovf_d   = rm_ovf_q;
    running_d  = running_q;
    load_out   = 1'b0;

    we         = '0;
    tick_waddr = slot_q;
    tick_wdata = wake_q;
    next_waddr = slot_q;
    next_wdata = at_q;
    prev_waddr = slot_q;
    prev_wdata = before_q;
    raddr      = slot_c;

    unique case (state_q)
      StIdle: begin
        if (in_data_i.func == FuncInsert) begin
          raddr = cmp_hit ? ovf_head_q[SlotW-1:0] : cur_head_q[SlotW-1:0];
        end else begin
          raddr = slot_c;
        end
        if (accept) begin
          slot_d   = slot_c;
          id_d     = in_data_i.timer_id;
          func_d   = in_data_i.func;
          wake_d   = wake_c;
          ovf_d    = cmp_hit;
          at_d     = cmp_hit ? ovf_head_q : cur_head_q;
          before_d = '0;
          status_d = StatOk;
          if (in_data_i.func == FuncInsert) begin
            if (!in_data_i.has_action) begin
              status_d = StatNoAction;
              state_d  = StDone;
            end else if (running_q[slot_c]) begin
              status_d = StatRunning;
              state_d  = StDone;
            end else if (cmp_hit ? ovf_head_q[SlotW] : cur_head_q[SlotW]) begin
              state_d = StWalk;
            end else begin
              state_d = StLink1;
            end
          end else begin
            if (!running_q[slot_c]) begin
              status_d = StatNotActive;
              state_d  = StDone;
            end else begin
              state_d = StRmLink;
            end
          end
        end
      end

      StWalk: begin
        // read data belongs to at_q; advance while the entry sorts ahead
        raddr = rd_next[SlotW-1:0];
        if (cmp_hit) begin
          before_d = at_q;
          at_d     = rd_next;
          if (!rd_next[SlotW]) begin
            state_d = StLink1;
          end
        end else begin
          state_d = StLink1;
        end
      end

      StLink1: begin
        we.tick = 1'b1;
        we.next = 1'b1;
        we.prev = 1'b1;
        state_d = StLink2;
      end

      StLink2: begin
        we.prev    = at_q[SlotW];
        prev_waddr = at_q[SlotW-1:0];
        prev_wdata = self_link;
        we.next    = before_q[SlotW];
        next_waddr = before_q[SlotW-1:0];
        next_wdata = self_link;
        if (!before_q[SlotW]) begin
          if (ovf_q) begin
            ovf_head_d = self_link;
            ovf_tick_d = wake_q;
          end else begin
            cur_head_d = self_link;
            cur_tick_d = wake_q;
          end
        end
        running_d[slot_q] = 1'b1;
        state_d = StDone;
      end

      StRmLink: begin
        // bridge the neighbours, then fetch the tick of the new head
        we.next    = rd_prev[SlotW];
        next_waddr = rd_prev[SlotW-1:0];
        next_wdata = rd_next;
        we.prev    = rd_next[SlotW];
        prev_waddr = rd_next[SlotW-1:0];
        prev_wdata = rd_prev;
        raddr      = rd_next[SlotW-1:0];
        rm_cur_d   = (cur_head_q == self_link);
        rm_ovf_d   = (ovf_head_q == self_link);
        if (cur_head_q == self_link) begin
          cur_head_d = rd_next;
        end
        if (ovf_head_q == self_link) begin
          ovf_head_d = rd_next;
        end
        running_d[slot_q] = 1'b0;
        state_d = StRmTick;
      end

      StRmTick: begin
        if (rm_cur_q) begin
          cur_tick_d = rd_tick;
        end
        if (rm_ovf_q) begin
          ovf_tick_d = rd_tick;
        end
        state_d = StDone;
      end

      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Result word; only a successful insert reports a wake tick.
  logic ok_insert;
  assign ok_insert = (status_q == StatOk) && (func_q == FuncInsert);

  always_comb begin
    out_d                = out_q;
    out_valid_d          = out_valid_q;
    if (load_out) begin
      out_valid_d          = 1'b1;
      out_d.status         = status_q;
      out_d.slot_id        = id_q;
      out_d.wake_time      = ok_insert ? WordTickW'(wake_q) : '0;
      out_d.went_overflow  = ok_insert && ovf_q;
      out_d.cur_head_valid = cur_head_q[SlotW];
      out_d.cur_head_id    = cur_head_q[SlotW] ? IdW'(cur_head_q[SlotW-1:0]) : '0;
      out_d.cur_head_tick  = cur_head_q[SlotW] ? WordTickW'(cur_tick_q) : '0;
      out_d.ovf_head_valid = ovf_head_q[SlotW];
      out_d.ovf_head_id    = ovf_head_q[SlotW] ? IdW'(ovf_head_q[SlotW-1:0]) : '0;
      out_d.ovf_head_tick  = ovf_head_q[SlotW] ? WordTickW'(ovf_tick_q) : '0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_head_q  <= '0;
      cur_tick_q  <= '0;
      ovf_head_q  <= '0;
      ovf_tick_q  <= '0;
      rm_cur_q    <= 1'b0;
      rm_ovf_q    <= 1'b0;
      running_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_head_q  <= cur_head_d;
      cur_tick_q  <= cur_tick_d;
      ovf_head_q  <= ovf_head_d;
      ovf_tick_q  <= ovf_tick_d;
      rm_cur_q    <= rm_cur_d;
      rm_ovf_q    <= rm_ovf_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    id_q     <= id_d;
    func_q   <= func_d;
    status_q <= status_d;
    wake_q   <= wake_d;
    ovf_q    <= ovf_d;
    at_q     <= at_d;
    before_q <= before_d;
    out_q    <= out_d;
  end

endmodule
